// ===== hw/rtl/kss_pkg.sv =====
// Shared types and codes for the KMP substring search block.
package kss_pkg;

	// Request kind carried on s_tuser.
	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	// Input side tdata width (byte_value only).
	localparam int unsigned IN_DATA_W  = 8;
	// Output side tdata: match_position[15:0], pattern_overflow[16], zero pad to 24.
	localparam int unsigned POS_W      = 16;
	localparam int unsigned OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WALK,
		ST_FINISH
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;    // request accepted this cycle
		logic fetch;   // pick up failure value of previous pattern position
		logic walk;    // one step of the failure chain
		logic finish;  // close out a text byte
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic item_text;     // incoming request is a text byte
		logic item_walk;     // incoming request needs the failure chain
		logic walk_done;     // chain step found its end
		logic text_q;        // request in flight is a text byte
		logic emit_blocked;  // result pending but output register still full
	} status_t;

endpackage

// ===== hw/rtl/kss_ctrl.sv =====
// Controller state machine for the KMP substring search block.
module kss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  kss_pkg::status_t status,
	output kss_pkg::cmd_t    cmd
);

	kss_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kss_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (status.item_text) begin
						state_d = status.item_walk ? kss_pkg::ST_WALK : kss_pkg::ST_FINISH;
					end else begin
						state_d = status.item_walk ? kss_pkg::ST_FETCH : kss_pkg::ST_IDLE;
					end
				end
			end
			kss_pkg::ST_FETCH: begin
				state_d = kss_pkg::ST_WALK;
			end
			kss_pkg::ST_WALK: begin
				if (status.walk_done) begin
					state_d = status.text_q ? kss_pkg::ST_FINISH : kss_pkg::ST_IDLE;
				end
			end
			kss_pkg::ST_FINISH: begin
				if (!status.emit_blocked) begin
					state_d = kss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kss_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			kss_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			kss_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			kss_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
			end
			kss_pkg::ST_FINISH: begin
				cmd.finish = !status.emit_blocked;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/kss_datapath.sv =====
// Datapath for the KMP substring search: pattern and failure memories, search state, result register.
module kss_datapath #(
	parameter int unsigned      PATTERN_DEPTH = 64,
	parameter longint unsigned  TEXT_LIMIT    = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kss_pkg::cmd_t                     cmd,
	output kss_pkg::status_t                  status,
	input  logic [kss_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [kss_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser
);

	localparam int unsigned AW  = $clog2(PATTERN_DEPTH);
	localparam int unsigned LW  = $clog2(PATTERN_DEPTH + 1);
	localparam int unsigned TPW = $clog2(TEXT_LIMIT + 1);
	localparam int unsigned SW  = (TPW > kss_pkg::POS_W) ? TPW : kss_pkg::POS_W;

	// memories
	logic [7:0]    store_mem [PATTERN_DEPTH];
	logic [AW-1:0] fail_mem  [PATTERN_DEPTH];
	logic [7:0]    store_rd_q;
	logic [AW-1:0] fail_rd_q;

	// search / pattern state
	logic [LW-1:0]  plen_q;
	logic [AW-1:0]  pmlen_q;
	logic [TPW-1:0] tpos_q;
	logic           done_q;
	logic           ovf_q;
	logic           pcomp_q;

	// request in flight
	logic [LW-1:0]  k_q, k_d;
	logic [7:0]     c_q;
	logic           last_q;
	logic           text_q;
	logic           walked_q;

	// result register
	logic                     out_valid_q;
	logic                     found_q;
	logic [kss_pkg::POS_W-1:0] pos_q;
	logic                     ovf_out_q;

	logic          is_text;
	logic [LW-1:0] q_idx;
	logic          full;
	logic          text_active;
	logic          eq;
	logic          walk_done;
	logic [LW-1:0] kn;
	logic          match;
	logic          emit;
	logic          tpos_below;
	logic [SW-1:0] start_pos;
	logic          fail_we;
	logic [AW-1:0] fail_wa;
	logic [AW-1:0] fail_wd;
	logic          store_we;

	assign is_text     = (s_tuser == kss_pkg::CMD_TEXT);
	assign q_idx       = pcomp_q ? '0 : plen_q;
	assign full        = (q_idx >= LW'(PATTERN_DEPTH));
	assign tpos_below  = (tpos_q < TPW'(TEXT_LIMIT));
	assign text_active = !done_q && tpos_below && (plen_q != '0);

	assign eq        = (store_rd_q == c_q);
	assign walk_done = eq || (k_q == '0);
	assign kn        = eq ? (k_q + LW'(1)) : '0;

	assign match     = walked_q && (k_q == plen_q);
	assign emit      = !done_q && (match || last_q);
	assign start_pos = SW'(tpos_q) + SW'(1) - SW'(plen_q);

	assign status.item_text    = is_text;
	assign status.item_walk    = is_text ? text_active : (!full && (q_idx != '0));
	assign status.walk_done    = walk_done;
	assign status.text_q       = text_q;
	assign status.emit_blocked = emit && out_valid_q && !m_tready;

	// next walk index; memory reads follow it so read data lines up with k_q
	always_comb begin
		k_d = k_q;
		if (cmd.load) begin
			k_d = is_text ? LW'(pmlen_q) : q_idx;
		end else if (cmd.fetch) begin
			k_d = LW'(fail_rd_q);
		end else if (cmd.walk) begin
			k_d = walk_done ? kn : LW'(fail_rd_q);
		end
	end

	assign store_we = cmd.load && !is_text && !full;
	assign fail_we  = (store_we && (q_idx == '0)) || (cmd.walk && walk_done && !text_q);
	assign fail_wa  = cmd.load ? '0 : AW'(plen_q - LW'(1));
	assign fail_wd  = cmd.load ? '0 : kn[AW-1:0];

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[q_idx[AW-1:0]] <= s_tdata;
		end
		store_rd_q <= store_mem[k_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fail_we) begin
			fail_mem[fail_wa] <= fail_wd;
		end
		fail_rd_q <= fail_mem[AW'(k_d[AW-1:0] - AW'(1))];
	end

	// payload of the request in flight
	always_ff @(posedge clk) begin
		k_q <= k_d;
		if (cmd.load) begin
			c_q      <= s_tdata;
			last_q   <= s_tlast;
			text_q   <= is_text;
			walked_q <= is_text && text_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q  <= '0;
			pmlen_q <= '0;
			tpos_q  <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
			pcomp_q <= 1'b1;
		end else begin
			if (cmd.load && !is_text) begin
				pcomp_q <= s_tlast;
				if (pcomp_q) begin
					pmlen_q <= '0;
					tpos_q  <= '0;
					done_q  <= 1'b0;
				end
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					ovf_q  <= pcomp_q ? 1'b0 : ovf_q;
					plen_q <= q_idx + LW'(1);
				end
			end else if (cmd.load) begin
				pcomp_q <= 1'b1;
			end else if (cmd.finish) begin
				if (last_q) begin
					pmlen_q <= '0;
					tpos_q  <= '0;
					done_q  <= 1'b0;
				end else begin
					if (walked_q) begin
						pmlen_q <= match ? '0 : k_q[AW-1:0];
						done_q  <= match;
					end
					if (!done_q && tpos_below) begin
						tpos_q <= tpos_q + TPW'(1);
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && emit) begin
			found_q   <= match;
			pos_q     <= match ? start_pos[kss_pkg::POS_W-1:0] : '0;
			ovf_out_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(kss_pkg::OUT_DATA_W - kss_pkg::POS_W - 1){1'b0}}, ovf_out_q, pos_q};

`ifndef SYNTHESIS
	a_pmlen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pmlen_q == '0) || (LW'(pmlen_q) < plen_q))
		else $error("matched prefix not shorter than pattern");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (k_q < plen_q))
		else $error("failure walk index beyond pattern");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (plen_q == LW'(PATTERN_DEPTH)))
		else $error("overflow flagged on a pattern that is not full");

	a_match_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && match && !last_q) |=> (done_q && (pmlen_q == '0)))
		else $error("match did not close the search");
`endif

endmodule

// ===== hw/rtl/kmp_substring_search.sv =====
// Top level of the KMP first-occurrence substring search block.
//
// Pattern bytes (s_tuser = 0) are loaded one per request and the failure
// table is extended as each one arrives; s_tlast closes the pattern, and the
// next pattern byte after that starts a new one. Bytes past PATTERN_DEPTH are
// dropped and set a sticky overflow flag reported with every result. Text
// bytes (s_tuser = 1) run through the KMP automaton; the first full match
// returns one result with found = 1 and its start index, and a text that ends
// (s_tlast) with no match returns found = 0, position 0. After a match the
// rest of that text is silent. Text bytes at index TEXT_LIMIT or above do not
// take part in matching. A text byte during pattern loading closes the
// pattern. The failure chain is walked one link per cycle, reading
// the pattern store and the failure table in parallel from two registered
// memories. The first pattern byte and a dropped byte are taken in the idle
// state alone; any other pattern byte goes through the fetch state and then
// walks the chain for at least one step. A text byte that does no matching
// goes straight to the finish state; otherwise it walks the chain first.
// Chain steps average under two per byte. A result waiting in the output
// register does not stop the block from taking requests; only a text byte
// that has its own result to hand over waits for the register to free.
module kmp_substring_search #(
	parameter int unsigned     PATTERN_DEPTH = 64,    // pattern capacity, 2..1024
	parameter longint unsigned TEXT_LIMIT    = 65536  // text positions searched
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [kss_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] byte_value
	input  logic                           s_tuser,   // [0] command: 0 pattern, 1 text
	input  logic                           s_tlast,   // is_last
	// result side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [kss_pkg::OUT_DATA_W-1:0] m_tdata,   // [15:0] match_position,
	                                                  // [16] pattern_overflow, [23:17] zero
	output logic                           m_tuser    // [0] found
);

	kss_pkg::cmd_t    cmd;
	kss_pkg::status_t status;

	kss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	kss_datapath #(
		.PATTERN_DEPTH (PATTERN_DEPTH),
		.TEXT_LIMIT    (TEXT_LIMIT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
